// ===== hw/rtl/ihx_pkg.sv =====
package ihx_pkg;

  // Frame layout offsets (bytes from destination MAC)
  localparam int unsigned ETH_HDR_LEN = 14;
  localparam int unsigned OFF_ETYPE   = 12;
  localparam int unsigned OFF_PROTO   = 23;
  localparam int unsigned OFF_SRC_IP  = 26;
  localparam int unsigned OFF_DST_IP  = 30;
  localparam int unsigned IP_MIN_END  = 34;

  localparam logic [7:0] ETYPE_IP_HI = 8'h08;
  localparam logic [7:0] ETYPE_IP_LO = 8'h00;
  localparam logic [7:0] PROTO_TCP   = 8'd6;
  localparam logic [7:0] PROTO_UDP   = 8'd17;

  localparam int unsigned TCP_HDR_LEN = 20;
  localparam int unsigned UDP_HDR_LEN = 8;

  // Offsets inside the transport header
  localparam logic [3:0] L4_SPORT_HI = 4'd0;
  localparam logic [3:0] L4_SPORT_LO = 4'd1;
  localparam logic [3:0] L4_DPORT_HI = 4'd2;
  localparam logic [3:0] L4_DPORT_LO = 4'd3;
  localparam logic [3:0] L4_DOFF     = 4'd12;
  localparam logic [3:0] L4_FLAGS    = 4'd13;
  localparam int unsigned L4_SPAN    = 14;

  // Queue sizes
  localparam int unsigned REC_DEPTH = 4;
  localparam int unsigned REC_PTR_W = $clog2(REC_DEPTH);
  localparam int unsigned OUT_DEPTH = 2;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);

  typedef enum logic [1:0] {
    TR_NONE = 2'd0,
    TR_TCP  = 2'd1,
    TR_UDP  = 2'd2
  } transport_e;

  // Fields captured from one frame, handed from front to back
  typedef struct packed {
    logic [15:0] len;
    logic        eth_ok;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  proto;
    logic [6:0]  toff;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [3:0]  doff;
    logic [7:0]  flags;
  } rec_t;

  // One summary as presented on the result ports
  typedef struct packed {
    logic        is_ipv4;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  ip_protocol;
    transport_e  transport;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  tcp_flags;
    logic [15:0] frame_length;
    logic [15:0] payload_length;
  } res_t;

endpackage

// ===== hw/rtl/ihx_front.sv =====
module ihx_front import ihx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       rec_push_o,
  output rec_t       rec_o
);

  logic [15:0] cnt_q, cnt_d, cnt_inc;
  logic        etype_hi_q, etype_hi_d;
  logic        eth_ok_q, eth_ok_d;
  logic [31:0] src_q, src_d, dst_q, dst_d;
  logic [7:0]  proto_q, proto_d;
  logic [6:0]  toff_q, toff_d;
  logic [15:0] sport_q, sport_d, dport_q, dport_d;
  logic [3:0]  doff_q, doff_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] rel;
  logic        in_l4;

  // saturating byte counter, length of frame including this beat
  assign cnt_inc = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;

  always_comb begin
    cnt_d = cnt_q;
    if (accept_i) begin
      cnt_d = last_byte_i ? 16'd0 : cnt_inc;
    end
  end

  // transport offset is known as the IHL byte goes past
  always_comb begin
    toff_d = toff_q;
    if (accept_i && cnt_q == 16'(ETH_HDR_LEN)) begin
      toff_d = 7'(ETH_HDR_LEN) + {1'b0, data_byte_i[3:0], 2'b00};
    end
  end

  assign rel   = cnt_q - {9'd0, toff_d};
  assign in_l4 = (cnt_q >= {9'd0, toff_d}) && (rel < 16'(L4_SPAN));

  // field capture on the fly; the bytes read all lie in this frame
  always_comb begin
    etype_hi_d = etype_hi_q;
    eth_ok_d   = eth_ok_q;
    src_d      = src_q;
    dst_d      = dst_q;
    proto_d    = proto_q;
    sport_d    = sport_q;
    dport_d    = dport_q;
    doff_d     = doff_q;
    flags_d    = flags_q;
    if (accept_i) begin
      if (cnt_q == 16'(OFF_ETYPE)) begin
        etype_hi_d = (data_byte_i == ETYPE_IP_HI);
      end
      if (cnt_q == 16'(OFF_ETYPE + 1)) begin
        eth_ok_d = etype_hi_q && (data_byte_i == ETYPE_IP_LO);
      end
      if (cnt_q == 16'(OFF_PROTO)) begin
        proto_d = data_byte_i;
      end
      if (cnt_q >= 16'(OFF_SRC_IP) && cnt_q < 16'(OFF_SRC_IP + 4)) begin
        src_d = {src_q[23:0], data_byte_i};
      end
      if (cnt_q >= 16'(OFF_DST_IP) && cnt_q < 16'(OFF_DST_IP + 4)) begin
        dst_d = {dst_q[23:0], data_byte_i};
      end
      if (in_l4) begin
        case (rel[3:0])
          L4_SPORT_HI: sport_d = {data_byte_i, sport_q[7:0]};
          L4_SPORT_LO: sport_d = {sport_q[15:8], data_byte_i};
          L4_DPORT_HI: dport_d = {data_byte_i, dport_q[7:0]};
          L4_DPORT_LO: dport_d = {dport_q[15:8], data_byte_i};
          L4_DOFF:     doff_d  = data_byte_i[7:4];
          L4_FLAGS:    flags_d = data_byte_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    etype_hi_q <= etype_hi_d;
    eth_ok_q   <= eth_ok_d;
    src_q      <= src_d;
    dst_q      <= dst_d;
    proto_q    <= proto_d;
    toff_q     <= toff_d;
    sport_q    <= sport_d;
    dport_q    <= dport_d;
    doff_q     <= doff_d;
    flags_q    <= flags_d;
  end

  // record built from the next values so the last beat counts
  assign rec_push_o = accept_i && last_byte_i;
  always_comb begin
    rec_o.len    = cnt_inc;
    rec_o.eth_ok = eth_ok_d;
    rec_o.src_ip = src_d;
    rec_o.dst_ip = dst_d;
    rec_o.proto  = proto_d;
    rec_o.toff   = toff_d;
    rec_o.sport  = sport_d;
    rec_o.dport  = dport_d;
    rec_o.doff   = doff_d;
    rec_o.flags  = flags_d;
  end

  a_cnt_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_push_o |=> cnt_q == 16'd0)
    else $error("byte counter not restarted after last beat");

endmodule

// ===== hw/rtl/ihx_rec_fifo.sv =====
module ihx_rec_fifo import ihx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output rec_t rdata_o
);

  rec_t                 mem_q [REC_DEPTH];
  logic [REC_PTR_W-1:0] wr_q, rd_q;
  logic [REC_PTR_W:0]   cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == (REC_PTR_W+1)'(REC_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (REC_PTR_W+1)'(REC_DEPTH))
    else $error("record queue level out of range");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("record queue popped while empty");

endmodule

// ===== hw/rtl/ihx_back.sv =====
module ihx_back import ihx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic rec_empty_i,
  input  rec_t rec_i,
  output logic rec_pop_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t res_o
);

  res_t                 oq_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_q, rd_q;
  logic [OUT_PTR_W:0]   cnt_q;
  logic                 do_pop;
  res_t                 res;
  logic [16:0]          len_x, toff_x;
  logic [7:0]           used;
  logic                 ipv4, tcp_fit, udp_fit;

  // take a record whenever the result queue has room
  assign rec_pop_o = !rec_empty_i && (cnt_q != (OUT_PTR_W+1)'(OUT_DEPTH));
  assign do_pop    = pop_i && !empty_o;
  assign empty_o   = (cnt_q == '0);
  assign res_o     = oq_q[rd_q];

  // classify and size the frame
  assign len_x   = {1'b0, rec_i.len};
  assign toff_x  = {10'd0, rec_i.toff};
  assign used    = {1'b0, rec_i.toff} + {2'b00, rec_i.doff, 2'b00};
  assign ipv4    = rec_i.eth_ok && (rec_i.len >= 16'(IP_MIN_END));
  assign tcp_fit = (rec_i.proto == PROTO_TCP) && (toff_x + 17'(TCP_HDR_LEN) <= len_x);
  assign udp_fit = (rec_i.proto == PROTO_UDP) && (toff_x + 17'(UDP_HDR_LEN) <= len_x);

  always_comb begin
    res = '0;
    res.transport = TR_NONE;
    if (ipv4) begin
      res.is_ipv4     = 1'b1;
      res.src_ip      = rec_i.src_ip;
      res.dst_ip      = rec_i.dst_ip;
      res.ip_protocol = rec_i.proto;
      if (tcp_fit) begin
        res.transport      = TR_TCP;
        res.src_port       = rec_i.sport;
        res.dst_port       = rec_i.dport;
        res.tcp_flags      = rec_i.flags;
        res.frame_length   = rec_i.len;
        res.payload_length = (rec_i.len > {8'd0, used}) ? rec_i.len - {8'd0, used} : 16'd0;
      end else if (udp_fit) begin
        res.transport      = TR_UDP;
        res.src_port       = rec_i.sport;
        res.dst_port       = rec_i.dport;
        res.frame_length   = rec_i.len;
        res.payload_length = rec_i.len - {9'd0, rec_i.toff} - 16'(UDP_HDR_LEN);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      oq_q[wr_q] <= res;
    end
  end

  // result queue pointers and level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (rec_pop_o) wr_q <= wr_q + 1'b1;
      if (do_pop)    rd_q <= rd_q + 1'b1;
      case ({rec_pop_o, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_transport_needs_ip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && res_o.transport != TR_NONE) |-> res_o.is_ipv4)
    else $error("transport reported on a non-IPv4 frame");

  a_out_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (OUT_PTR_W+1)'(OUT_DEPTH))
    else $error("result queue level out of range");

endmodule

// ===== hw/rtl/ipv4_l4_header_extractor.sv =====
// Ethernet / IPv4 / TCP-UDP header extractor.
//
// Input queue: one frame byte per beat on data_byte_i, last_byte_i high on
// the final byte. A beat is taken on a clock edge with push high and full
// low. Bytes are accepted every cycle while full is low; full rises only
// when the internal queue of four parsed frames has filled behind a stalled
// receiver. Result queue: one summary per frame, valid while empty is low,
// taken on an edge with pop high. The summary is registered first in the
// frame queue and then in the result queue, and one summary per cycle can be
// drained, so frames of any length run at one byte per cycle if pop keeps up.
// Header fields are captured as the bytes stream past, so no frame buffer is
// read back; length and transport checks are done on the way out.
// Reset clears the byte counter and both queues; no clearing pass is needed.
// When the receiver stalls, up to two summaries wait in the result queue and
// four more in the frame queue before full is raised.
module ipv4_l4_header_extractor import ihx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        is_ipv4_o,
  output logic [31:0] src_ip_o,
  output logic [31:0] dst_ip_o,
  output logic [7:0]  ip_protocol_o,
  output logic [1:0]  transport_o,
  output logic [15:0] src_port_o,
  output logic [15:0] dst_port_o,
  output logic [7:0]  tcp_flags_o,
  output logic [15:0] frame_length_o,
  output logic [15:0] payload_length_o
);

  logic accept;
  logic rec_push, rec_pop, rec_empty;
  rec_t rec_w, rec_r;
  res_t res;

  assign accept = push && !full;

  ihx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .rec_push_o  (rec_push),
    .rec_o       (rec_w)
  );

  ihx_rec_fifo u_rec_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .wdata_i (rec_w),
    .full_o  (full),
    .pop_i   (rec_pop),
    .empty_o (rec_empty),
    .rdata_o (rec_r)
  );

  ihx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_empty_i (rec_empty),
    .rec_i       (rec_r),
    .rec_pop_o   (rec_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  // result fields out
  assign is_ipv4_o        = res.is_ipv4;
  assign src_ip_o         = res.src_ip;
  assign dst_ip_o         = res.dst_ip;
  assign ip_protocol_o    = res.ip_protocol;
  assign transport_o      = res.transport;
  assign src_port_o       = res.src_port;
  assign dst_port_o       = res.dst_port;
  assign tcp_flags_o      = res.tcp_flags;
  assign frame_length_o   = res.frame_length;
  assign payload_length_o = res.payload_length;

endmodule
